FILE: hdl/rwvc_pkg.sv
// Shared types, register codes and constants of the wheel voltage command block.
package rwvc_pkg;

   localparam int RWVC_WHEEL_COUNT = 4;

   // quotient bits produced by the shared divider (one per cycle)
   localparam int RWVC_DIV_STEPS = 32;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [2:0] REG_FEEDBACK_GAIN = 3'd0;
   localparam logic [2:0] REG_VOLTAGE_MAX   = 3'd1;
   localparam logic [2:0] REG_VOLTAGE_MIN   = 3'd2;
   localparam logic [2:0] REG_INERTIA       = 3'd3;
   localparam logic [2:0] REG_TORQUE_LIMIT  = 3'd4;

   localparam logic [29:0] NS_PER_S = 30'd1000000000;

   typedef struct packed {
      logic [1:0]         wheel_index;
      logic signed [31:0] torque_cmd;
      logic signed [31:0] wheel_speed;
      logic               wheel_available;
      logic               speed_valid;
      logic [63:0]        call_time;
      logic               last_wheel;
   } req_type;

   typedef struct packed {
      logic [1:0]         wheel_number;
      logic signed [31:0] voltage_cmd;
   } rsp_type;

   typedef struct packed {
      logic [30:0] feedback_gain;
      logic [30:0] voltage_max;
      logic [30:0] voltage_min;
      logic [63:0] inertia_table;
      logic [63:0] torque_limit_table;
   } cfg_type;

endpackage

FILE: hdl/rwvc_csr.sv
// Configuration register file behind the APB-style port.
module rwvc_csr import rwvc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic [2:0] reg_index;
   logic       wr_beat;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1:3];
   assign wr_beat    = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_beat) begin
         unique case (reg_index)
            REG_FEEDBACK_GAIN: cfg_ff.feedback_gain      <= csr_pwdata[30:0];
            REG_VOLTAGE_MAX:   cfg_ff.voltage_max        <= csr_pwdata[30:0];
            REG_VOLTAGE_MIN:   cfg_ff.voltage_min        <= csr_pwdata[30:0];
            REG_INERTIA:       cfg_ff.inertia_table      <= csr_pwdata;
            REG_TORQUE_LIMIT:  cfg_ff.torque_limit_table <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_FEEDBACK_GAIN: csr_prdata = {33'd0, cfg_ff.feedback_gain};
         REG_VOLTAGE_MAX:   csr_prdata = {33'd0, cfg_ff.voltage_max};
         REG_VOLTAGE_MIN:   csr_prdata = {33'd0, cfg_ff.voltage_min};
         REG_INERTIA:       csr_prdata = cfg_ff.inertia_table;
         REG_TORQUE_LIMIT:  csr_prdata = cfg_ff.torque_limit_table;
         default:           csr_prdata = '0;
      endcase
   end

endmodule

FILE: hdl/rwvc_speed_mem.sv
// Per-wheel previous speed store: synchronous memory with valid bits.
module rwvc_speed_mem import rwvc_pkg::*; #(
   parameter int DEPTH = RWVC_WHEEL_COUNT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [31:0]                            rd_data,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [31:0]                            wr_data
);

   logic [31:0]      mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [31:0]      rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // a never-written entry reads as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : 32'd0;

endmodule

FILE: hdl/rwvc_divider.sv
// Shared restoring divider: 32 quotient bits, one per cycle, with overflow flag.
module rwvc_divider import rwvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] numer,
   input  logic [63:0] denom,
   output logic        done,
   output logic [31:0] quot,
   output logic        ovf
);

   localparam int CNT_W = $clog2(RWVC_DIV_STEPS + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RWVC_DIV_STEPS - 1);

   logic [63:0]      rem_ff;
   logic [31:0]      low_ff;
   logic [63:0]      den_ff;
   logic             ovf_ff;
   logic [CNT_W-1:0] count_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [64:0]      shifted;
   logic             fits;
   logic [64:0]      diff;

   assign shifted = {rem_ff, low_ff[31]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   // payload: quotient of the upper half decides overflow, the lower half iterates
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {32'd0, numer[63:32]};
         low_ff <= numer[31:0];
         den_ff <= denom;
         ovf_ff <= {32'd0, numer[63:32]} >= denom;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[63:0] : shifted[63:0];
         low_ff <= {low_ff[30:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = low_ff;
   assign ovf  = ovf_ff;

endmodule

FILE: hdl/reaction_wheel_voltage_command.sv
// Top level: sequencer and arithmetic of the reaction wheel voltage command.
//
// One beat on the req channel carries one wheel sample (torque command, speed,
// availability, speed-valid flag, call time, last-wheel marker). Each sample
// yields exactly one beat on the rsp channel with the wheel number and the
// saturated Q16.16 voltage command, in order.
// Items are worked one at a time. The previous speed of each wheel lives in a
// small synchronous memory, read when the beat is taken and written back when
// the result is formed. Acceleration feedback and the torque-to-voltage scale
// each run through one shared divider that yields one quotient bit per cycle.
// An item with feedback runs the acceleration division, then the multiply and
// correction steps and, where a torque limit is set, the voltage division; an
// item with a voltage division but no feedback runs only that division; one
// with no division at all runs neither. The next beat is taken in the cycle
// after the result is loaded into the output register.
// req_stall is high from acceptance until the result is formed. When rsp_stall
// holds a waiting result, the block finishes the next item and then waits with
// it until the output register frees.
// Reset clears the sequencer, the configuration, the speed memory valid bits
// (all speeds read as zero), the stored call time and sets the skip flag.
module reaction_wheel_voltage_command import rwvc_pkg::*; #(
   parameter int WHEEL_COUNT = RWVC_WHEEL_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
   localparam logic [2:0] WHEEL_LIMIT = 3'(WHEEL_COUNT);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_LOAD   = 4'd1;
   localparam logic [3:0] ST_SCALE  = 4'd2;
   localparam logic [3:0] ST_DIVA   = 4'd3;
   localparam logic [3:0] ST_DIVA_W = 4'd4;
   localparam logic [3:0] ST_JMUL   = 4'd5;
   localparam logic [3:0] ST_ERR    = 4'd6;
   localparam logic [3:0] ST_CORR   = 4'd7;
   localparam logic [3:0] ST_SAT    = 4'd8;
   localparam logic [3:0] ST_VMUL   = 4'd9;
   localparam logic [3:0] ST_VMAG   = 4'd10;
   localparam logic [3:0] ST_DIVB   = 4'd11;
   localparam logic [3:0] ST_DIVB_W = 4'd12;
   localparam logic [3:0] ST_OUT    = 4'd13;

   cfg_type cfg;

   // control state
   logic [3:0]  state_ff, state_in;
   logic [63:0] prev_time_ff;
   logic        skip_ff;
   logic        rsp_valid_ff;

   // item payload and intermediate results
   req_type            item_ff;
   rsp_type            rsp_data_ff;
   logic               diff_neg_ff;
   logic [32:0]        diff_mag_ff;
   logic [63:0]        dt_ff;
   logic               store_ff;
   logic               fb_ff;
   logic [63:0]        num_ff;
   logic [31:0]        amag_ff;
   logic [31:0]        jm_ff;
   logic               err_neg_ff;
   logic [32:0]        err_mag_ff;
   logic [47:0]        cm_ff;
   logic signed [31:0] torque_ff;
   logic signed [63:0] p_ff;
   logic               pneg_ff;
   logic [31:0]        mq_ff;
   logic               movf_ff;

   logic        req_beat;
   logic        out_free;
   logic        in_range;
   logic        prev_nz;
   logic [5:0]  tbl_base;
   logic [15:0] inertia;
   logic [15:0] torque_lim;
   logic        use_div;

   logic [31:0] mem_rd_data;
   logic        mem_wr_en;

   logic        div_start;
   logic [63:0] div_denom;
   logic        div_done;
   logic [31:0] div_quot;
   logic        div_ovf;

   logic [32:0]        diff_full;
   logic [62:0]        scale_prod;
   logic [31:0]        amag;
   logic [47:0]        j_prod;
   logic [33:0]        jacc;
   logic [33:0]        err_full;
   logic [33:0]        err_abs;
   logic [63:0]        c_prod;
   logic [49:0]        torque_ext;
   logic [49:0]        t_corr;
   logic [31:0]        t_sat;
   logic signed [31:0] slope;
   logic signed [63:0] p_prod;
   logic [32:0]        v_sum;
   logic               v_big;
   logic [30:0]        v_mag;
   logic [31:0]        v_out;

   rwvc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rwvc_speed_mem #(
      .DEPTH (WHEEL_COUNT)
   ) u_speed_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_beat),
      .rd_addr (req_data.wheel_index[IDX_W-1:0]),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (item_ff.wheel_index[IDX_W-1:0]),
      .wr_data (item_ff.wheel_speed)
   );

   rwvc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (num_ff),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot),
      .ovf   (div_ovf)
   );

   // handshake
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // per-item decode
   assign in_range   = {1'b0, item_ff.wheel_index} < WHEEL_LIMIT;
   assign prev_nz    = prev_time_ff != 64'd0;
   assign tbl_base   = {item_ff.wheel_index, 4'd0};
   assign inertia    = cfg.inertia_table[tbl_base +: 16];
   assign torque_lim = cfg.torque_limit_table[tbl_base +: 16];
   assign use_div    = in_range && item_ff.wheel_available && (torque_lim != 16'd0);

   assign mem_wr_en = (state_ff == ST_OUT) && out_free && store_ff;
   assign div_start = (state_ff == ST_DIVA) || (state_ff == ST_DIVB);
   assign div_denom = (state_ff == ST_DIVB) ? {44'd0, torque_lim, 4'd0} : dt_ff;

   // speed step and its scaling to ns
   assign diff_full  = {item_ff.wheel_speed[31], item_ff.wheel_speed}
                       - {mem_rd_data[31], mem_rd_data};
   assign scale_prod = 63'(diff_mag_ff) * 63'(NS_PER_S);

   // saturate the acceleration magnitude to the signed 32-bit range
   always_comb begin
      if (diff_neg_ff) begin
         amag = (div_ovf || div_quot > 32'h8000_0000) ? 32'h8000_0000 : div_quot;
      end else begin
         amag = (div_ovf || div_quot[31]) ? 32'h7FFF_FFFF : div_quot;
      end
   end

   // inertia times acceleration, then the torque error
   assign j_prod   = 48'(inertia) * 48'(amag_ff);
   assign jacc     = diff_neg_ff ? (34'd0 - {2'd0, jm_ff}) : {2'd0, jm_ff};
   assign err_full = jacc - {{2{torque_ff[31]}}, torque_ff};
   assign err_abs  = err_full[33] ? (34'd0 - err_full) : err_full;

   // gain times error, then the corrected and saturated torque
   assign c_prod     = 64'(cfg.feedback_gain) * 64'(err_mag_ff);
   assign torque_ext = {{18{torque_ff[31]}}, torque_ff};
   assign t_corr     = err_neg_ff ? (torque_ext + {2'd0, cm_ff})
                                  : (torque_ext - {2'd0, cm_ff});
   always_comb begin
      if (t_corr[49:31] == {19{t_corr[49]}}) begin
         t_sat = t_corr[31:0];
      end else begin
         t_sat = t_corr[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
   end

   // torque to voltage: slope product, dead-zone offset, clamp
   assign slope  = $signed({1'b0, cfg.voltage_max}) - $signed({1'b0, cfg.voltage_min});
   assign p_prod = slope * torque_ff;
   assign v_sum  = {1'b0, mq_ff} + {2'd0, cfg.voltage_min};
   assign v_big  = movf_ff || (v_sum > {2'd0, cfg.voltage_max});
   assign v_mag  = v_big ? cfg.voltage_max : v_sum[30:0];
   always_comb begin
      if ((mq_ff == 32'd0) && !movf_ff) begin
         v_out = 32'd0;
      end else if (pneg_ff) begin
         v_out = 32'd0 - {1'b0, v_mag};
      end else begin
         v_out = {1'b0, v_mag};
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_beat) state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_SCALE;
         ST_SCALE:  state_in = fb_ff ? ST_DIVA : ST_VMUL;
         ST_DIVA:   state_in = ST_DIVA_W;
         ST_DIVA_W: if (div_done) state_in = ST_JMUL;
         ST_JMUL:   state_in = ST_ERR;
         ST_ERR:    state_in = ST_CORR;
         ST_CORR:   state_in = ST_SAT;
         ST_SAT:    state_in = ST_VMUL;
         ST_VMUL:   state_in = ST_VMAG;
         ST_VMAG:   state_in = use_div ? ST_DIVB : ST_OUT;
         ST_DIVB:   state_in = ST_DIVB_W;
         ST_DIVB_W: if (div_done) state_in = ST_OUT;
         ST_OUT:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_time_ff <= '0;
         skip_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
            // commit the call time on the last wheel of a call with valid speeds
            if (item_ff.last_wheel && item_ff.speed_valid) begin
               if (prev_nz) begin
                  skip_ff <= 1'b0;
               end
               prev_time_ff <= item_ff.call_time;
            end
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         item_ff <= req_data;
      end
      unique case (state_ff)
         ST_LOAD: begin
            diff_neg_ff <= diff_full[32];
            diff_mag_ff <= diff_full[32] ? (33'd0 - diff_full) : diff_full;
            dt_ff       <= item_ff.call_time - prev_time_ff;
            torque_ff   <= item_ff.torque_cmd;
            store_ff    <= in_range && item_ff.speed_valid && prev_nz;
            fb_ff       <= in_range && item_ff.speed_valid && prev_nz
                           && item_ff.wheel_available && !skip_ff
                           && (item_ff.call_time != prev_time_ff);
         end
         ST_SCALE: num_ff <= {1'b0, scale_prod};
         ST_DIVA_W: begin
            if (div_done) begin
               amag_ff <= amag;
            end
         end
         ST_JMUL: jm_ff <= j_prod[47:16];
         ST_ERR: begin
            err_neg_ff <= err_full[33];
            err_mag_ff <= err_abs[32:0];
         end
         ST_CORR: cm_ff <= c_prod[63:16];
         ST_SAT:  torque_ff <= t_sat;
         ST_VMUL: p_ff <= p_prod;
         ST_VMAG: begin
            pneg_ff <= p_ff[63];
            num_ff  <= p_ff[63] ? (64'd0 - p_ff) : p_ff;
            mq_ff   <= 32'd0;
            movf_ff <= 1'b0;
         end
         ST_DIVB_W: begin
            if (div_done) begin
               mq_ff   <= div_quot;
               movf_ff <= div_ovf;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_data_ff.wheel_number <= item_ff.wheel_index;
               rsp_data_ff.voltage_cmd  <= v_out;
            end
         end
         default: ;
      endcase
   end

   // an accepted beat always starts the memory read cycle
   assert property (@(posedge clock) disable iff (reset)
      req_beat |=> state_ff == ST_LOAD)
      else $error("accepted beat did not start a load");

   // the skip flag clears only when an item commits its call time
   assert property (@(posedge clock) disable iff (reset)
      $fell(skip_ff) |-> $past(state_ff == ST_OUT && item_ff.last_wheel
                               && item_ff.speed_valid))
      else $error("skip flag cleared outside a commit");

   // a result appears only from the output step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output step");

   // divider completions land only while the sequencer waits for them
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVA_W || state_ff == ST_DIVB_W))
      else $error("divider finished while not awaited");

endmodule

FILE: tb/tb_reaction_wheel_voltage_command.sv
// Self-checking bench for the reaction wheel voltage command block.
module tb_reaction_wheel_voltage_command;
   import rwvc_pkg::*;

   typedef longint unsigned u64_t;

   localparam u64_t   SECOND_NS   = 64'd1000000000;
   localparam longint S32_MAX     = 64'sd2147483647;
   localparam longint S32_MIN     = -64'sd2147483648;
   localparam int     CYCLE_LIMIT = 1500000;
   // Long enough for a feedback item to drain out of the block.
   localparam int     SETTLE      = 120;
   localparam int     LONG_HOLD   = 400;
   localparam int     PHASES      = 8;
   localparam int     PHASE_ITEMS = 210;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_data;
   logic    csr_psel    = 1'b0;
   logic    csr_penable = 1'b0;
   logic    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr  = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   reaction_wheel_voltage_command uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // Shadow copy of the register file, updated when a write lands.
   u64_t       cfg_gain    = 0;
   u64_t       cfg_vmax    = 0;
   u64_t       cfg_vmin    = 0;
   logic [63:0] cfg_inertia = '0;
   logic [63:0] cfg_tlim    = '0;

   // Shadow copy of the block's wheel history.
   longint     last_speed [4] = '{default: 0};
   u64_t       last_call_ns   = 0;
   bit         feedback_held  = 1'b1;

   req_type    pending_samples[$];
   rsp_type    expected_voltages[$];

   int gap_max   = 0;
   int burst_max = 0;
   int stall_pct = 0;
   int burst_left = 0;
   int gap_left   = 0;
   int stall_run  = 0;
   int hold_left  = 0;
   int hold_orders = 0;
   int holds_served = 0;

   int mismatches    = 0;
   int samples_taken = 0;
   int voltages_seen = 0;
   int feedback_runs = 0;
   int settings_used = 0;
   int cycle_count   = 0;

   int   walk_speed [4] = '{default: 0};
   u64_t now_ns = 64'd100000000;

   rsp_type got_exp;

   function automatic u64_t magnitude(longint v);
      u64_t m;
      m = (v < 0) ? -v : v;
      return m;
   endfunction

   function automatic longint apply_sign(bit neg, u64_t m);
      longint s;
      s = m;
      return neg ? -s : s;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
   endfunction

   // Work out the voltage of one wheel sample and advance the shadow history.
   function automatic rsp_type predict_voltage(req_type s);
      int      w;
      longint  torque, speed, diff, accel, jaccel, err, corr, slope, prod, volt, vmax, vmin;
      u64_t    dt, q, jm, cm, lim, m;
      rsp_type r;
      w      = s.wheel_index;
      torque = $signed(s.torque_cmd);
      speed  = $signed(s.wheel_speed);
      vmax   = cfg_vmax;
      vmin   = cfg_vmin;
      volt   = 0;
      if (s.speed_valid && last_call_ns != 0) begin
         dt = s.call_time - last_call_ns;
         if (s.wheel_available && !feedback_held && dt != 0) begin
            feedback_runs++;
            diff   = speed - last_speed[w];
            q      = (magnitude(diff) * SECOND_NS) / dt;
            accel  = clamp32(apply_sign(diff < 0, q));
            jm     = (u64_t'(cfg_inertia[w*16 +: 16]) * magnitude(accel)) >> 16;
            jaccel = apply_sign(accel < 0, jm);
            err    = jaccel - torque;
            cm     = (cfg_gain * magnitude(err)) >> 16;
            corr   = apply_sign(err < 0, cm);
            torque = clamp32(torque - corr);
         end
         last_speed[w] = speed;
      end
      if (s.wheel_available) begin
         lim = cfg_tlim[w*16 +: 16];
         if (lim != 0) begin
            slope = vmax - vmin;
            prod  = slope * torque;
            m     = magnitude(prod) / (lim * 16);
            volt  = apply_sign(prod < 0, m);
         end
         if (volt > 0) volt = volt + vmin;
         if (volt < 0) volt = volt - vmin;
         if (volt > vmax) volt = vmax;
         if (volt < -vmax) volt = -vmax;
      end
      // commit the call time on the last wheel of a call
      if (s.last_wheel && s.speed_valid) begin
         if (last_call_ns != 0) feedback_held = 1'b0;
         last_call_ns = s.call_time;
      end
      r.wheel_number = s.wheel_index;
      r.voltage_cmd  = volt[31:0];
      return r;
   endfunction

   function automatic req_type make_sample(int w, logic [31:0] torque, logic [31:0] speed,
                                           bit avail, bit valid, logic [63:0] t, bit last);
      req_type s;
      s.wheel_index     = w[1:0];
      s.torque_cmd      = torque;
      s.wheel_speed     = speed;
      s.wheel_available = avail;
      s.speed_valid     = valid;
      s.call_time       = t;
      s.last_wheel      = last;
      return s;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] random_table(int lo, int hi);
      return {16'($urandom_range(lo, hi)), 16'($urandom_range(lo, hi)),
              16'($urandom_range(lo, hi)), 16'($urandom_range(lo, hi))};
   endfunction

   // Driver: offer pending samples in bursts, hold a stalled beat steady.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_voltages.push_back(predict_voltage(req_data));
            samples_taken++;
         end
         // advance only when the slot is empty or its beat just went through
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               req_data  <= pending_samples.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, burst_max);
                  gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall in random runs, or hold off for a long stretch on order.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_orders != holds_served) begin
         holds_served++;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (stall_run > 0) begin
         stall_run--;
      end else begin
         stall_run = $urandom_range(0, 7);
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Monitor: compare each accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         voltages_seen++;
         if (expected_voltages.size() == 0) begin
            $display("%0t: unexpected result, expected none, got wheel %0d voltage %0d",
                     $time, rsp_data.wheel_number, rsp_data.voltage_cmd);
            mismatches++;
         end else begin
            got_exp = expected_voltages.pop_front();
            if (rsp_data.wheel_number !== got_exp.wheel_number) begin
               $display("%0t: wheel_number expected %0d got %0d",
                        $time, got_exp.wheel_number, rsp_data.wheel_number);
               mismatches++;
            end
            if (rsp_data.voltage_cmd !== got_exp.voltage_cmd) begin
               $display("%0t: voltage_cmd wheel %0d expected %0d got %0d", $time,
                        got_exp.wheel_number, got_exp.voltage_cmd, rsp_data.voltage_cmd);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: drop the run if it never drains.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_voltages.size());
         $display("tb: failure");
         $finish;
      end
   end

   // One register write: setup cycle, then access cycle until pready.
   task automatic csr_write(logic [2:0] code, logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {code, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (code)
         REG_FEEDBACK_GAIN: cfg_gain    = value[30:0];
         REG_VOLTAGE_MAX:   cfg_vmax    = value[30:0];
         REG_VOLTAGE_MIN:   cfg_vmin    = value[30:0];
         REG_INERTIA:       cfg_inertia = value;
         REG_TORQUE_LIMIT:  cfg_tlim    = value;
         default: ;
      endcase
   endtask

   task automatic load_config(logic [63:0] gain, logic [63:0] vmax, logic [63:0] vmin,
                              logic [63:0] inertia, logic [63:0] tlim);
      csr_write(REG_FEEDBACK_GAIN, gain);
      csr_write(REG_VOLTAGE_MAX, vmax);
      csr_write(REG_VOLTAGE_MIN, vmin);
      csr_write(REG_INERTIA, inertia);
      csr_write(REG_TORQUE_LIMIT, tlim);
      settings_used++;
   endtask

   // Hold until every sample is taken and every voltage is back, then settle.
   task automatic wait_idle();
      while (pending_samples.size() != 0 || req_valid || expected_voltages.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Pick idling and a register setting for one random phase.
   task automatic phase_setup(int p);
      logic [63:0] vmax;
      vmax = $urandom_range(1 << 16, 24 << 16);
      case (p)
         0: begin
            gap_max = 0; burst_max = 0; stall_pct = 0;
            load_config($urandom_range(0, 4 << 16), vmax, $urandom_range(0, 1 << 16),
                        random_table(100, 8000), random_table(200, 4095));
         end
         1: begin
            gap_max = 3; burst_max = 4; stall_pct = 60;
            load_config(0, vmax, $urandom_range(0, 1 << 16),
                        random_table(100, 8000), random_table(200, 4095));
         end
         2: begin
            gap_max = 12; burst_max = 2; stall_pct = 20;
            load_config(64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF, '1, '1);
         end
         3: begin
            // minimum above maximum, wheel 2 without a torque limit
            gap_max = 5; burst_max = 3; stall_pct = 30;
            load_config($urandom_range(0, 4 << 16), vmax, vmax + $urandom_range(1, 4 << 16),
                        random_table(100, 8000),
                        random_table(200, 4095) & 64'hFFFF_0000_FFFF_FFFF);
            hold_orders++;
         end
         4: begin
            gap_max = 2; burst_max = 6; stall_pct = 50;
            load_config(0, 0, 0, 0, 0);
         end
         5: begin
            gap_max = 8; burst_max = 3; stall_pct = 40;
            load_config($urandom, $urandom, $urandom, rand64(), rand64());
         end
         6: begin
            gap_max = 1; burst_max = 8; stall_pct = 10;
            load_config($urandom_range(0, 8 << 16), vmax, $urandom_range(0, 1 << 16),
                        random_table(1, 65535), random_table(1, 65535));
            hold_orders++;
         end
         default: begin
            gap_max = 20; burst_max = 8; stall_pct = 80;
            load_config($urandom, $urandom, $urandom, rand64(), rand64());
         end
      endcase
   endtask

   // Queue control calls with random content, plus noise and broken calls.
   task automatic random_traffic(int count);
      int   made, pick, n, first, w, k;
      bit   valid, drop_last;
      logic [31:0] torque, speed;
      u64_t dt;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 99) < 15) begin
            pending_samples.push_back(make_sample($urandom_range(0, 3), $urandom, $urandom,
                                                  $urandom_range(0, 1), $urandom_range(0, 1),
                                                  rand64(), $urandom_range(0, 1)));
            made++;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 8)       dt = 0;
            else if (pick < 12) dt = $urandom_range(1, 1000);
            else if (pick < 15) dt = rand64();
            else                dt = $urandom_range(1000000, 50000000);
            now_ns    = now_ns + dt;
            n         = $urandom_range(1, 4);
            first     = $urandom_range(0, 3);
            valid     = ($urandom_range(0, 9) != 0);
            drop_last = ($urandom_range(0, 9) == 0);
            for (k = 0; k < n; k++) begin
               w = (first + k) % 4;
               if ($urandom_range(0, 9) == 0) walk_speed[w] = $urandom;
               else walk_speed[w] = walk_speed[w] + int'($urandom_range(0, 131072)) - 65536;
               speed  = walk_speed[w];
               torque = ($urandom_range(0, 3) == 0) ? $urandom
                                                     : int'($urandom_range(0, 65536)) - 32768;
               pending_samples.push_back(make_sample(w, torque, speed,
                                                     $urandom_range(0, 9) != 0, valid, now_ns,
                                                     (k == n - 1) && !drop_last));
               made++;
            end
         end
      end
   endtask

   initial begin
      u64_t t0;
      int   p;
      t0 = 64'd5000000;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part under a plain setting, no idling.
      load_config(64'h8000, 12 << 16, 64'h8000,
                  {16'd800, 16'd700, 16'd600, 16'd655}, {16'd1000, 16'd900, 16'd819, 16'd819});
      // no call committed yet: torque extremes, zero torque, unavailable wheel
      pending_samples.push_back(make_sample(0, 32'h7FFFFFFF, 0, 1, 1, t0, 0));
      pending_samples.push_back(make_sample(1, 32'h80000000, 0, 1, 1, t0, 0));
      pending_samples.push_back(make_sample(2, 0, 0, 1, 1, t0, 0));
      pending_samples.push_back(make_sample(3, 1 << 16, 0, 0, 1, t0, 1));
      // second call: speeds stored, skip flag clears on the last wheel
      pending_samples.push_back(make_sample(0, 32'h4000, 1 << 16, 1, 1, t0 + 10000000, 0));
      pending_samples.push_back(make_sample(1, 32'hFFFFC000, 2 << 16, 1, 1, t0 + 10000000, 0));
      pending_samples.push_back(make_sample(2, 32'h2000, 32'hFFFD0000, 1, 1, t0 + 10000000, 0));
      pending_samples.push_back(make_sample(3, 32'h1000, 32'h7FFFFFFF, 1, 1, t0 + 10000000, 1));
      // third call: feedback, one saturating speed step, two zero steps
      pending_samples.push_back(make_sample(0, 32'h8000, 2 << 16, 1, 1, t0 + 20000000, 0));
      pending_samples.push_back(make_sample(1, 32'hFFFF8000, 32'h80000000, 1, 1,
                                            t0 + 20000000, 0));
      pending_samples.push_back(make_sample(2, 32'h7FFFFFFF, 32'hFFFD0000, 1, 1,
                                            t0 + 20000000, 0));
      pending_samples.push_back(make_sample(3, 32'h80000000, 32'h7FFFFFFF, 1, 1,
                                            t0 + 20000000, 1));
      // zero dt skips feedback
      pending_samples.push_back(make_sample(0, 32'h8000, 5 << 16, 1, 1, t0 + 20000000, 0));
      // speeds not valid: no store, no commit
      pending_samples.push_back(make_sample(1, 32'h8000, 9 << 16, 1, 0, t0 + 25000000, 1));
      // call time runs backwards, dt wraps
      pending_samples.push_back(make_sample(1, 32'h8000, 3 << 16, 1, 1, 64'd1, 1));
      // commit at time zero forgets the prior call
      pending_samples.push_back(make_sample(2, 32'h8000, 0, 1, 1, 64'd0, 1));
      pending_samples.push_back(make_sample(3, 32'h8000, 1 << 16, 1, 1, 64'd7000000, 1));
      // one nanosecond after the commit
      pending_samples.push_back(make_sample(0, 32'h8000, 32'h80000000, 1, 1, 64'd7000001, 0));
      wait_idle();

      // minimum above maximum, zero torque limit on wheel 1, largest gain
      load_config(64'h7FFFFFFF, 2 << 16, 5 << 16,
                  {16'hFFFF, 16'h0001, 16'h8000, 16'h0000}, {16'd819, 16'd2000, 16'd0, 16'd819});
      pending_samples.push_back(make_sample(1, 1 << 16, 0, 1, 1, 64'd9000000, 0));
      pending_samples.push_back(make_sample(0, 1 << 16, 0, 1, 1, 64'd9000000, 0));
      pending_samples.push_back(make_sample(2, 32'hFFFF0000, 0, 1, 1, 64'd9000000, 0));
      pending_samples.push_back(make_sample(3, 32'h7FFFFFFF, 0, 1, 1, 64'd9000000, 1));
      wait_idle();

      // Random phases; each ends with the sender paused until all voltages return.
      for (p = 0; p < PHASES; p++) begin
         phase_setup(p);
         random_traffic(PHASE_ITEMS);
         wait_idle();
      end

      $display("summary: %0d samples, %0d voltages, %0d feedback updates, %0d register settings",
               samples_taken, voltages_seen, feedback_runs, settings_used);
      $display("summary: %0d long receiver hold-offs, %0d mismatches", holds_served, mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: reaction_wheel_voltage_command.f
hdl/rwvc_pkg.sv
hdl/rwvc_csr.sv
hdl/rwvc_speed_mem.sv
hdl/rwvc_divider.sv
hdl/reaction_wheel_voltage_command.sv
tb/tb_reaction_wheel_voltage_command.sv
